// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property checked at every rising clock edge outside reset.
`define ACP_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

// Same-cycle implication checked at every rising clock edge outside reset.
`define ACP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	`ACP_ASSERT(label, clk, rst_n, (ante) |-> (cons), msg)

`endif

// ===== rtl/acp_pkg.sv =====
package acp_pkg;

	// Coordinate and size width, and the width of a size product.
	localparam int DIM_BITS  = 16;
	localparam int PROD_BITS = 2 * DIM_BITS;

	// Divider step counter holds the number of quotient bits.
	localparam int CNT_BITS = $clog2(DIM_BITS + 1);

	// Command queue between front and back.
	localparam int FIFO_DEPTH = 2;
	localparam int PTR_BITS   = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int LVL_BITS   = $clog2(FIFO_DEPTH + 1);

	// Configuration register index width.
	localparam int CFG_IDX_BITS = 3;

	typedef logic        [DIM_BITS-1:0]  dim_t;
	typedef logic signed [DIM_BITS-1:0]  coord_t;
	typedef logic        [PROD_BITS-1:0] prod_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_SCALE_MODE = 3'd0,
		CFG_CANVAS_X   = 3'd1,
		CFG_CANVAS_Y   = 3'd2,
		CFG_CANVAS_W   = 3'd3,
		CFG_CANVAS_H   = 3'd4
	} cfg_idx_t;

	typedef enum logic {
		MODE_FILL      = 1'b0,
		MODE_LETTERBOX = 1'b1
	} scale_mode_t;

	localparam dim_t CANVAS_W_RST = dim_t'(1920);
	localparam dim_t CANVAS_H_RST = dim_t'(1080);

	// One classified item on its way from front to back.
	typedef struct packed {
		logic        bad;
		scale_mode_t mode;
		logic        wide;
		prod_t       dividend;
		dim_t        divisor;
		coord_t      pic_x;
		coord_t      pic_y;
		dim_t        pic_w;
		dim_t        pic_h;
		coord_t      canvas_x;
		coord_t      canvas_y;
		dim_t        canvas_w;
		dim_t        canvas_h;
	} cmd_t;

	// Divider status seen by the back end.
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	typedef enum logic [1:0] {
		BK_IDLE = 2'd0,
		BK_RUN  = 2'd1,
		BK_WRAP = 2'd2
	} bk_state_t;

endpackage

// ===== rtl/acp_front.sv =====
module acp_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  acp_pkg::coord_t                     pic_x,
	input  acp_pkg::coord_t                     pic_y,
	input  acp_pkg::dim_t                       pic_w,
	input  acp_pkg::dim_t                       pic_h,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [acp_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  acp_pkg::dim_t                       cfg_data,
	output logic                                q_push,
	input  logic                                q_full,
	output acp_pkg::cmd_t                       q_data
);

	// Configuration registers.
	acp_pkg::scale_mode_t mode_q;
	acp_pkg::coord_t      canvas_x_q;
	acp_pkg::coord_t      canvas_y_q;
	acp_pkg::dim_t        canvas_w_q;
	acp_pkg::dim_t        canvas_h_q;

	// First stage: captured item and both cross products.
	logic            valid_s1;
	acp_pkg::coord_t pic_x_s1;
	acp_pkg::coord_t pic_y_s1;
	acp_pkg::dim_t   pic_w_s1;
	acp_pkg::dim_t   pic_h_s1;
	acp_pkg::prod_t  prod_a_s1;
	acp_pkg::prod_t  prod_b_s1;
	logic            bad_s1;

	logic advance;
	logic accept;
	logic a_gt_b;
	logic b_gt_a;
	logic wide;

	assign cfg_ready = 1'b1;

	// Register writes; an unknown index is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= acp_pkg::MODE_FILL;
			canvas_x_q <= '0;
			canvas_y_q <= '0;
			canvas_w_q <= acp_pkg::CANVAS_W_RST;
			canvas_h_q <= acp_pkg::CANVAS_H_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				acp_pkg::CFG_SCALE_MODE: mode_q <= acp_pkg::scale_mode_t'(cfg_data[0]);
				acp_pkg::CFG_CANVAS_X:   canvas_x_q <= acp_pkg::coord_t'(cfg_data);
				acp_pkg::CFG_CANVAS_Y:   canvas_y_q <= acp_pkg::coord_t'(cfg_data);
				acp_pkg::CFG_CANVAS_W:   canvas_w_q <= cfg_data;
				acp_pkg::CFG_CANVAS_H:   canvas_h_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// The stage moves whenever it is empty or the queue takes its item.
	assign advance = !valid_s1 || !q_full;
	assign full    = !advance;
	assign accept  = push && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= push;
		end
	end

	// Capture the item and form pic_w*canvas_h and canvas_w*pic_h.
	always_ff @(posedge clk) begin
		if (accept) begin
			pic_x_s1  <= pic_x;
			pic_y_s1  <= pic_y;
			pic_w_s1  <= pic_w;
			pic_h_s1  <= pic_h;
			prod_a_s1 <= acp_pkg::prod_t'(pic_w) * acp_pkg::prod_t'(canvas_h_q);
			prod_b_s1 <= acp_pkg::prod_t'(canvas_w_q) * acp_pkg::prod_t'(pic_h);
			bad_s1    <= (pic_w == '0) || (pic_h == '0) ||
			             (canvas_w_q == '0) || (canvas_h_q == '0);
		end
	end

	// Classify by aspect and pick the product and divisor for the back end.
	assign a_gt_b = prod_a_s1 > prod_b_s1;
	assign b_gt_a = prod_b_s1 > prod_a_s1;
	assign wide   = (mode_q == acp_pkg::MODE_FILL) ? a_gt_b : b_gt_a;

	always_comb begin
		q_data          = '0;
		q_data.bad      = bad_s1;
		q_data.mode     = mode_q;
		q_data.wide     = wide;
		q_data.pic_x    = pic_x_s1;
		q_data.pic_y    = pic_y_s1;
		q_data.pic_w    = pic_w_s1;
		q_data.pic_h    = pic_h_s1;
		q_data.canvas_x = canvas_x_q;
		q_data.canvas_y = canvas_y_q;
		q_data.canvas_w = canvas_w_q;
		q_data.canvas_h = canvas_h_q;
		case ({mode_q, wide})
			{acp_pkg::MODE_FILL, 1'b1}: begin
				q_data.dividend = prod_b_s1;
				q_data.divisor  = canvas_h_q;
			end
			{acp_pkg::MODE_FILL, 1'b0}: begin
				q_data.dividend = prod_a_s1;
				q_data.divisor  = canvas_w_q;
			end
			{acp_pkg::MODE_LETTERBOX, 1'b1}: begin
				q_data.dividend = prod_a_s1;
				q_data.divisor  = pic_h_s1;
			end
			default: begin
				q_data.dividend = prod_b_s1;
				q_data.divisor  = pic_w_s1;
			end
		endcase
	end

	assign q_push = valid_s1 && !q_full;

endmodule

// ===== rtl/acp_fifo.sv =====
`include "assert_macros.svh"

module acp_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  acp_pkg::cmd_t din,
	input  logic          pop,
	output logic          empty,
	output acp_pkg::cmd_t dout
);

	acp_pkg::cmd_t                   entry_q [acp_pkg::FIFO_DEPTH];
	logic [acp_pkg::PTR_BITS-1:0]    wr_ptr_q;
	logic [acp_pkg::PTR_BITS-1:0]    rd_ptr_q;
	logic [acp_pkg::LVL_BITS-1:0]    level_q;
	logic                            do_push;
	logic                            do_pop;

	function automatic logic [acp_pkg::PTR_BITS-1:0] ptr_next(
		input logic [acp_pkg::PTR_BITS-1:0] ptr
	);
		return (ptr == acp_pkg::PTR_BITS'(acp_pkg::FIFO_DEPTH - 1)) ? '0 : ptr + 1'b1;
	endfunction

	assign full    = level_q == acp_pkg::LVL_BITS'(acp_pkg::FIFO_DEPTH);
	assign empty   = level_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = entry_q[rd_ptr_q];

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				level_q <= level_q + 1'b1;
			end else if (do_pop && !do_push) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= din;
		end
	end

	`ACP_ASSERT(a_level_bound, clk, arst_n, level_q <= acp_pkg::LVL_BITS'(acp_pkg::FIFO_DEPTH), "queue level above depth")

endmodule

// ===== rtl/acp_div.sv =====
`include "assert_macros.svh"

module acp_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  acp_pkg::prod_t     dividend,
	input  acp_pkg::dim_t      divisor,
	output acp_pkg::div_stat_t stat,
	output acp_pkg::dim_t      quotient
);

	// The quotient is known to fit in DIM_BITS, so the upper half of the
	// dividend is already below the divisor and seeds the remainder.
	acp_pkg::dim_t                rem_q;
	acp_pkg::dim_t                quo_q;
	acp_pkg::dim_t                dsr_q;
	logic [acp_pkg::CNT_BITS-1:0] cnt_q;
	logic                         busy_q;
	logic                         done_q;

	logic [acp_pkg::DIM_BITS:0] trial;
	logic [acp_pkg::DIM_BITS:0] diff;
	logic                       fits;

	assign trial = {rem_q, quo_q[acp_pkg::DIM_BITS-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign fits  = trial >= {1'b0, dsr_q};

	// Control: count one quotient bit per cycle, pulse done after the last.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= acp_pkg::CNT_BITS'(acp_pkg::DIM_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == acp_pkg::CNT_BITS'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Restoring shift-subtract datapath.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[acp_pkg::PROD_BITS-1:acp_pkg::DIM_BITS];
			quo_q <= dividend[acp_pkg::DIM_BITS-1:0];
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[acp_pkg::DIM_BITS-1:0] : trial[acp_pkg::DIM_BITS-1:0];
			quo_q <= {quo_q[acp_pkg::DIM_BITS-2:0], fits};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;

	`ACP_ASSERT_IMPL(a_rem_below_dsr, clk, arst_n, busy_q, rem_q < dsr_q, "remainder not below divisor")
	`ACP_ASSERT_IMPL(a_busy_count, clk, arst_n, busy_q, cnt_q != '0, "divider busy with zero count")

endmodule

// ===== rtl/acp_back.sv =====
`include "assert_macros.svh"

module acp_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_empty,
	output logic            q_pop,
	input  acp_pkg::cmd_t   q_data,
	input  logic            pop,
	output logic            empty,
	output acp_pkg::coord_t pos_x,
	output acp_pkg::coord_t pos_y,
	output acp_pkg::dim_t   pos_w,
	output acp_pkg::dim_t   pos_h,
	output acp_pkg::coord_t clip_x,
	output acp_pkg::coord_t clip_y,
	output acp_pkg::dim_t   clip_w,
	output acp_pkg::dim_t   clip_h,
	output logic            bad_size
);

	acp_pkg::bk_state_t state_q;
	acp_pkg::bk_state_t state_d;
	acp_pkg::cmd_t      cmd_q;

	logic               div_start;
	acp_pkg::div_stat_t div_stat;
	acp_pkg::dim_t      quotient;

	logic load_cmd;
	logic load_out;
	logic out_free;

	acp_pkg::dim_t   span;
	acp_pkg::dim_t   off;
	acp_pkg::coord_t r_pos_x;
	acp_pkg::coord_t r_pos_y;
	acp_pkg::dim_t   r_pos_w;
	acp_pkg::dim_t   r_pos_h;
	acp_pkg::coord_t r_clip_x;
	acp_pkg::coord_t r_clip_y;
	acp_pkg::dim_t   r_clip_w;
	acp_pkg::dim_t   r_clip_h;

	// Output register.
	logic            out_valid_q;
	acp_pkg::coord_t pos_x_q;
	acp_pkg::coord_t pos_y_q;
	acp_pkg::dim_t   pos_w_q;
	acp_pkg::dim_t   pos_h_q;
	acp_pkg::coord_t clip_x_q;
	acp_pkg::coord_t clip_y_q;
	acp_pkg::dim_t   clip_w_q;
	acp_pkg::dim_t   clip_h_q;
	logic            bad_q;

	acp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (q_data.dividend),
		.divisor  (q_data.divisor),
		.stat     (div_stat),
		.quotient (quotient)
	);

	assign out_free = !out_valid_q || pop;

	// Sequencer: take an item, divide unless it is bad, then hand it over.
	always_comb begin
		state_d   = state_q;
		q_pop     = 1'b0;
		load_cmd  = 1'b0;
		div_start = 1'b0;
		load_out  = 1'b0;
		case (state_q)
			acp_pkg::BK_IDLE: begin
				if (!q_empty) begin
					q_pop     = 1'b1;
					load_cmd  = 1'b1;
					div_start = !q_data.bad;
					state_d   = q_data.bad ? acp_pkg::BK_WRAP : acp_pkg::BK_RUN;
				end
			end
			acp_pkg::BK_RUN: begin
				if (div_stat.done) begin
					state_d = acp_pkg::BK_WRAP;
				end
			end
			acp_pkg::BK_WRAP: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = acp_pkg::BK_IDLE;
				end
			end
			default: begin
				state_d = acp_pkg::BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= acp_pkg::BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (load_cmd) begin
			cmd_q <= q_data;
		end
	end

	// The span is the dimension the scaled size is centered in.
	always_comb begin
		case ({cmd_q.mode, cmd_q.wide})
			{acp_pkg::MODE_FILL, 1'b1}:      span = cmd_q.pic_w;
			{acp_pkg::MODE_FILL, 1'b0}:      span = cmd_q.pic_h;
			{acp_pkg::MODE_LETTERBOX, 1'b1}: span = cmd_q.canvas_w;
			default:                         span = cmd_q.canvas_h;
		endcase
	end

	assign off = (span - quotient) >> 1;

	// Assemble the two rectangles.
	always_comb begin
		r_pos_x  = '0;
		r_pos_y  = '0;
		r_pos_w  = '0;
		r_pos_h  = '0;
		r_clip_x = '0;
		r_clip_y = '0;
		r_clip_w = '0;
		r_clip_h = '0;
		if (!cmd_q.bad) begin
			if (cmd_q.mode == acp_pkg::MODE_FILL) begin
				r_pos_x = cmd_q.canvas_x;
				r_pos_y = cmd_q.canvas_y;
				r_pos_w = cmd_q.canvas_w;
				r_pos_h = cmd_q.canvas_h;
				if (cmd_q.wide) begin
					r_clip_x = acp_pkg::coord_t'(off);
					r_clip_w = quotient;
					r_clip_h = cmd_q.pic_h;
				end else begin
					r_clip_y = acp_pkg::coord_t'(off);
					r_clip_w = cmd_q.pic_w;
					r_clip_h = quotient;
				end
			end else begin
				r_clip_x = cmd_q.pic_x;
				r_clip_y = cmd_q.pic_y;
				r_clip_w = cmd_q.pic_w;
				r_clip_h = cmd_q.pic_h;
				if (cmd_q.wide) begin
					r_pos_x = acp_pkg::coord_t'(off);
					r_pos_w = quotient;
					r_pos_h = cmd_q.canvas_h;
				end else begin
					r_pos_y = acp_pkg::coord_t'(off);
					r_pos_w = cmd_q.canvas_w;
					r_pos_h = quotient;
				end
			end
		end
	end

	// Result register: holds one finished item until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			pos_x_q  <= r_pos_x;
			pos_y_q  <= r_pos_y;
			pos_w_q  <= r_pos_w;
			pos_h_q  <= r_pos_h;
			clip_x_q <= r_clip_x;
			clip_y_q <= r_clip_y;
			clip_w_q <= r_clip_w;
			clip_h_q <= r_clip_h;
			bad_q    <= cmd_q.bad;
		end
	end

	assign empty    = !out_valid_q;
	assign pos_x    = pos_x_q;
	assign pos_y    = pos_y_q;
	assign pos_w    = pos_w_q;
	assign pos_h    = pos_h_q;
	assign clip_x   = clip_x_q;
	assign clip_y   = clip_y_q;
	assign clip_w   = clip_w_q;
	assign clip_h   = clip_h_q;
	assign bad_size = bad_q;

	`ACP_ASSERT_IMPL(a_quot_in_span, clk, arst_n, (state_q == acp_pkg::BK_WRAP) && !cmd_q.bad, quotient <= span, "scaled size exceeds its span")
	`ACP_ASSERT_IMPL(a_run_busy, clk, arst_n, (state_q == acp_pkg::BK_RUN) && !div_stat.done, div_stat.busy, "divider idle while sequencer waits")

endmodule

// ===== rtl/aspect_fill_letterbox_geometry_core.sv =====
// Channel   Handshake                 Payload
// input     push / full               pic_x, pic_y, pic_w, pic_h
// result    empty / pop               pos_x..pos_h, clip_x..clip_h, bad_size
// config    cfg_valid / cfg_ready     cfg_index, cfg_data
//
// The front end accepts an item every cycle while its two-entry queue has room.
// In the back end each item then goes through the 16-step shift-subtract
// divider; an item with a zero size skips the divider.
// A finished item waits in the result register while the next one is divided.
// Reset is asynchronous and active low; the config port is always ready.
module aspect_fill_letterbox_geometry_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  acp_pkg::coord_t                   pic_x,
	input  acp_pkg::coord_t                   pic_y,
	input  acp_pkg::dim_t                     pic_w,
	input  acp_pkg::dim_t                     pic_h,
	output logic                              empty,
	input  logic                              pop,
	output acp_pkg::coord_t                   pos_x,
	output acp_pkg::coord_t                   pos_y,
	output acp_pkg::dim_t                     pos_w,
	output acp_pkg::dim_t                     pos_h,
	output acp_pkg::coord_t                   clip_x,
	output acp_pkg::coord_t                   clip_y,
	output acp_pkg::dim_t                     clip_w,
	output acp_pkg::dim_t                     clip_h,
	output logic                              bad_size,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [acp_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  acp_pkg::dim_t                     cfg_data
);

	logic          fq_push;
	logic          fq_full;
	acp_pkg::cmd_t fq_din;
	logic          fq_pop;
	logic          fq_empty;
	acp_pkg::cmd_t fq_dout;

	// Front end: config registers, products and aspect classification.
	acp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.pic_x     (pic_x),
		.pic_y     (pic_y),
		.pic_w     (pic_w),
		.pic_h     (pic_h),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_push    (fq_push),
		.q_full    (fq_full),
		.q_data    (fq_din)
	);

	// Command queue between the two halves.
	acp_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fq_push),
		.full   (fq_full),
		.din    (fq_din),
		.pop    (fq_pop),
		.empty  (fq_empty),
		.dout   (fq_dout)
	);

	// Back end: division, centering and the result register.
	acp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (fq_empty),
		.q_pop    (fq_pop),
		.q_data   (fq_dout),
		.pop      (pop),
		.empty    (empty),
		.pos_x    (pos_x),
		.pos_y    (pos_y),
		.pos_w    (pos_w),
		.pos_h    (pos_h),
		.clip_x   (clip_x),
		.clip_y   (clip_y),
		.clip_w   (clip_w),
		.clip_h   (clip_h),
		.bad_size (bad_size)
	);

endmodule
